FILE: rtl/pvff_pkg.sv
// Package for the protobuf varint field finder.
// Holds the decode state and result types, phase, status and wire type codes, and varint limits.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pvff_pkg;

    // Decode phases
    localparam logic [2:0] PH_TAG   = 3'd0;
    localparam logic [2:0] PH_VALUE = 3'd1;
    localparam logic [2:0] PH_SKIPV = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_SKIPB = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // Protobuf wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // Varint limits, fixed field sizes and the reset target field
    localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;
    localparam logic [31:0] FIX64_BYTES      = 32'd8;
    localparam logic [31:0] FIX32_BYTES      = 32'd4;
    localparam logic [31:0] TARGET_RESET     = 32'd1;

    // Decode state carried from one byte to the next
    typedef struct packed {
        logic [2:0]  phase;
        logic [63:0] accumulator;
        logic [3:0]  varint_byte_count;
        logic [31:0] skip_remaining;
        logic [2:0]  pending_wire_type;
        logic        result_given;
    } state_t;

    // One result item
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
    } result_t;

    // State of a fresh message
    localparam state_t STATE_CLEAR = '{
        phase:             PH_TAG,
        accumulator:       64'd0,
        varint_byte_count: 4'd0,
        skip_remaining:    32'd0,
        pending_wire_type: 3'd0,
        result_given:      1'b0
    };

endpackage

`default_nettype wire

FILE: rtl/protobuf_varint_field_finder.sv
// Bytes decode from the input register; results load into the result register.
// One byte per cycle unless in_stall is high; one pass of the decode state per byte.
// A byte that causes a result waits in the input register while the result register is full.
// Reset (rst_n, asynchronous, active low) clears the decode state and sets target_reg to 1.
// Depends on pvff_pkg, pvff_step and pvff_result.
`timescale 1ns / 1ps
`default_nettype none

module protobuf_varint_field_finder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [63:0]      value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] target_field
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic [31:0]       target_reg;
    pvff_pkg::state_t  state_reg;
    pvff_pkg::state_t  state_next;
    pvff_pkg::state_t  state_step;
    pvff_pkg::result_t res;
    logic              res_valid;
    logic              res_free;
    logic              advance;
    logic              in_accept;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= pvff_pkg::TARGET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_reg <= target_field;
        end
    end

    // Decode of the held byte
    pvff_step u_step (
        .state_cur    (state_reg),
        .data_byte    (byte_reg),
        .last_byte    (last_reg),
        .target_field (target_reg),
        .state_new    (state_step),
        .res_valid    (res_valid),
        .res          (res)
    );

    // The held byte retires unless its result finds the result register full
    assign advance   = in_valid_reg && (!res_valid || res_free);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        state_next = advance ? state_step : state_reg;
    end

    // Input register and decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= pvff_pkg::STATE_CLEAR;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // Result register
    pvff_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .free      (res_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .value     (value)
    );

    // Only a found result carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != pvff_pkg::ST_FOUND |-> value == 64'd0)
        else $error("non-found result carries a value");

    // No status code beyond malformed.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("invalid status code");

    // Once a message has its result, its later bytes give nothing.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && state_reg.result_given |-> !res_valid)
        else $error("second result for one message");

    // The last byte of a message leaves a clean state behind.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> state_reg.phase == pvff_pkg::PH_TAG
                                && !state_reg.result_given
                                && state_reg.varint_byte_count == 4'd0)
        else $error("state not cleared after last byte");

    // Every last byte of a message without an earlier result produces a result item.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && last_reg && !state_reg.result_given |-> res_valid)
        else $error("message ended without a result");

endmodule

`default_nettype wire

FILE: rtl/pvff_step.sv
// Next-state logic of the field finder: folds one message byte into the decode state.
// Decides whether the byte ends the search and forms the result item.
// Depends on pvff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvff_step (
    input  wire pvff_pkg::state_t  state_cur,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic [31:0]       target_field,
    output pvff_pkg::state_t       state_new,
    output logic                   res_valid,
    output pvff_pkg::result_t      res
);

    logic [6:0]  shift;
    logic [63:0] acc_new;
    logic [63:0] varint;
    logic [3:0]  count_inc;
    logic [31:0] skip_dec;
    logic [31:0] field_num;
    logic [2:0]  wire_type;

    // Merge the seven payload bits of this byte into the accumulator
    always_comb
    begin
        shift = 7'({3'd0, state_cur.varint_byte_count} * 7'd7);
        acc_new = state_cur.accumulator;
        if (shift < 7'd64)
        begin
            acc_new = state_cur.accumulator | ({57'd0, data_byte[6:0]} << shift[5:0]);
        end
        varint    = acc_new;
        count_inc = state_cur.varint_byte_count + 4'd1;
        skip_dec  = state_cur.skip_remaining
                    - {31'd0, (state_cur.skip_remaining != 32'd0)};
        field_num = varint[34:3];
        wire_type = varint[2:0];
    end

    // Phase update and result forming
    always_comb
    begin
        state_new = state_cur;
        res_valid = 1'b0;
        res       = '{status: pvff_pkg::ST_MALFORMED, value: 64'd0};

        if (!state_cur.result_given)
        begin
            if (state_cur.phase == pvff_pkg::PH_SKIPB)
            begin
                state_new.skip_remaining = skip_dec;
                if (skip_dec == 32'd0)
                begin
                    state_new.phase = pvff_pkg::PH_TAG;
                end
            end
            else if (state_cur.phase <= pvff_pkg::PH_LEN)
            begin
                if (data_byte[7])
                begin
                    // Continuation byte
                    state_new.accumulator       = acc_new;
                    state_new.varint_byte_count = count_inc;
                    if (count_inc >= pvff_pkg::MAX_VARINT_BYTES)
                    begin
                        res_valid = 1'b1;
                    end
                end
                else
                begin
                    // Final byte of a varint
                    state_new.accumulator       = 64'd0;
                    state_new.varint_byte_count = 4'd0;
                    case (state_cur.phase)
                        pvff_pkg::PH_TAG:
                        begin
                            state_new.pending_wire_type = wire_type;
                            if (wire_type == pvff_pkg::WT_VARINT && field_num == target_field)
                            begin
                                state_new.phase = pvff_pkg::PH_VALUE;
                            end
                            else
                            begin
                                case (wire_type)
                                    pvff_pkg::WT_VARINT:
                                    begin
                                        state_new.phase = pvff_pkg::PH_SKIPV;
                                    end
                                    pvff_pkg::WT_FIX64:
                                    begin
                                        state_new.skip_remaining = pvff_pkg::FIX64_BYTES;
                                        state_new.phase          = pvff_pkg::PH_SKIPB;
                                    end
                                    pvff_pkg::WT_FIX32:
                                    begin
                                        state_new.skip_remaining = pvff_pkg::FIX32_BYTES;
                                        state_new.phase          = pvff_pkg::PH_SKIPB;
                                    end
                                    pvff_pkg::WT_LEN:
                                    begin
                                        state_new.phase = pvff_pkg::PH_LEN;
                                    end
                                    default:
                                    begin
                                        res_valid = 1'b1;
                                    end
                                endcase
                            end
                        end
                        pvff_pkg::PH_VALUE:
                        begin
                            res_valid = 1'b1;
                            res       = '{status: pvff_pkg::ST_FOUND, value: varint};
                        end
                        pvff_pkg::PH_SKIPV:
                        begin
                            state_new.phase = pvff_pkg::PH_TAG;
                        end
                        default:
                        begin
                            // Length prefix of a delimited field
                            if (varint[63:32] != 32'd0)
                            begin
                                res_valid = 1'b1;
                            end
                            else if (varint == 64'd0)
                            begin
                                state_new.phase = pvff_pkg::PH_TAG;
                            end
                            else
                            begin
                                state_new.skip_remaining = varint[31:0];
                                state_new.phase          = pvff_pkg::PH_SKIPB;
                            end
                        end
                    endcase
                end
            end
            else
            begin
                res_valid = 1'b1;
            end

            // End of message without an earlier result
            if (last_byte && !res_valid)
            begin
                res_valid = 1'b1;
                if (state_new.phase == pvff_pkg::PH_TAG && state_new.varint_byte_count == 4'd0)
                begin
                    res.status = pvff_pkg::ST_NOT_FOUND;
                end
            end

            if (res_valid)
            begin
                state_new.result_given = 1'b1;
            end
        end

        // A new message starts after the last byte
        if (last_byte)
        begin
            state_new = pvff_pkg::STATE_CLEAR;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pvff_result.sv
// Result register of the field finder: holds one result item until it is taken.
// Depends on pvff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pvff_result (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire pvff_pkg::result_t res,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [63:0]            value
);

    logic              valid_reg;
    logic              valid_next;
    pvff_pkg::result_t data_reg;

    // The register can take a new item when empty or when its item leaves now
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded only while the register is free
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign status    = data_reg.status;
    assign value     = data_reg.value;

endmodule

`default_nettype wire

FILE: verif/tb_protobuf_varint_field_finder.sv
// Self-checking testbench for protobuf_varint_field_finder.
// Feeds encoded messages byte by byte and checks every result against its own decoder.
// Depends on pvff_pkg and the protobuf_varint_field_finder RTL.
`timescale 1ns / 1ps

module tb_protobuf_varint_field_finder;

    localparam int LIMIT_CYCLES   = 300000;
    localparam int PHASE_BYTES    = 190;
    localparam int HOLD_AT_BYTES  = 700;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 10;

    // One byte of the stream with its end-of-message flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [63:0] value;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] target_field = 32'd0;

    msg_byte_t         bytes_to_send[$];
    pvff_pkg::result_t results_due[$];
    logic [7:0]        msg_q[$];

    // Decoder copy and its register
    pvff_pkg::state_t  dec;
    logic [31:0]       wanted_field;

    int          error_count = 0;
    int          cycle_count = 0;
    int          bytes_in = 0;
    int          bytes_queued = 0;
    int          msg_count = 0;
    int          cfg_writes = 0;
    int          found_count = 0;
    int          absent_count = 0;
    int          malformed_count = 0;
    logic        byte_taken = 1'b0;

    // Sender burst state
    int          burst_left = 0;
    int          gap_left = 0;

    // Receiver stall state
    int          rx_cycle = 0;
    int          rx_mode = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;

    protobuf_varint_field_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .value        (value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .target_field (target_field)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run one accepted byte through the decoder and queue any result it causes.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic              hit;
        pvff_pkg::result_t res;
        logic [63:0]       word;
        logic [31:0]       field;
        logic [2:0]        wt;
        hit = 1'b0;
        res.status = pvff_pkg::ST_MALFORMED;
        res.value = 64'd0;
        if (!dec.result_given)
        begin
            if (dec.phase == pvff_pkg::PH_SKIPB)
            begin
                if (dec.skip_remaining != 32'd0)
                    dec.skip_remaining = dec.skip_remaining - 32'd1;
                if (dec.skip_remaining == 32'd0)
                    dec.phase = pvff_pkg::PH_TAG;
            end
            else if (dec.phase <= pvff_pkg::PH_LEN)
            begin
                // Groups past bit 63 fall off the accumulator.
                if (7 * dec.varint_byte_count < 64)
                    dec.accumulator = dec.accumulator
                                    | (64'(b[6:0]) << (7 * dec.varint_byte_count));
                if (b[7])
                begin
                    dec.varint_byte_count = dec.varint_byte_count + 4'd1;
                    if (dec.varint_byte_count >= pvff_pkg::MAX_VARINT_BYTES)
                        hit = 1'b1;
                end
                else
                begin
                    word = dec.accumulator;
                    dec.accumulator = 64'd0;
                    dec.varint_byte_count = 4'd0;
                    case (dec.phase)
                        pvff_pkg::PH_TAG:
                        begin
                            field = word[34:3];
                            wt = word[2:0];
                            dec.pending_wire_type = wt;
                            if (wt == pvff_pkg::WT_VARINT && field == wanted_field)
                                dec.phase = pvff_pkg::PH_VALUE;
                            else if (wt == pvff_pkg::WT_VARINT)
                                dec.phase = pvff_pkg::PH_SKIPV;
                            else if (wt == pvff_pkg::WT_FIX64)
                            begin
                                dec.skip_remaining = pvff_pkg::FIX64_BYTES;
                                dec.phase = pvff_pkg::PH_SKIPB;
                            end
                            else if (wt == pvff_pkg::WT_FIX32)
                            begin
                                dec.skip_remaining = pvff_pkg::FIX32_BYTES;
                                dec.phase = pvff_pkg::PH_SKIPB;
                            end
                            else if (wt == pvff_pkg::WT_LEN)
                                dec.phase = pvff_pkg::PH_LEN;
                            else
                                hit = 1'b1;
                        end
                        pvff_pkg::PH_VALUE:
                        begin
                            hit = 1'b1;
                            res.status = pvff_pkg::ST_FOUND;
                            res.value = word;
                        end
                        pvff_pkg::PH_SKIPV:
                            dec.phase = pvff_pkg::PH_TAG;
                        pvff_pkg::PH_LEN:
                        begin
                            if (word > 64'h0000_0000_FFFF_FFFF)
                                hit = 1'b1;
                            else if (word == 64'd0)
                                dec.phase = pvff_pkg::PH_TAG;
                            else
                            begin
                                dec.skip_remaining = word[31:0];
                                dec.phase = pvff_pkg::PH_SKIPB;
                            end
                        end
                        default:
                            hit = 1'b1;
                    endcase
                end
            end
            else
                hit = 1'b1;

            if (hit)
                dec.result_given = 1'b1;

            // The last byte must close a whole field, else the message is cut short.
            if (fin && !dec.result_given)
            begin
                hit = 1'b1;
                res.value = 64'd0;
                if (dec.phase == pvff_pkg::PH_TAG && dec.varint_byte_count == 4'd0)
                    res.status = pvff_pkg::ST_NOT_FOUND;
                else
                    res.status = pvff_pkg::ST_MALFORMED;
                dec.result_given = 1'b1;
            end
        end
        if (fin)
            dec = pvff_pkg::STATE_CLEAR;
        if (hit)
            results_due.insert(results_due.size(), res);
    endtask

    // Byte count of the shortest varint for a value
    function automatic int varint_len(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 64'd0)
            n++;
        return n;
    endfunction

    // Mostly minimal encodings, some padded, a few past the ten byte limit.
    function automatic int pick_len(input logic [63:0] v);
        int n;
        int r;
        n = varint_len(v);
        r = $urandom_range(0, 99);
        if (r < 10 && n < 10)
            n = n + $urandom_range(1, 10 - n);
        else if (r == 10)
            n = 11;
        return n;
    endfunction

    // Append a varint of nbytes bytes; groups beyond bit 63 carry random filler.
    task automatic put_varint(input logic [63:0] v, input int nbytes);
        logic [6:0] grp;
        logic [7:0] octet;
        for (int i = 0; i < nbytes; i++)
        begin
            if (i < 9)
                grp = 7'(v >> (7 * i));
            else if (i == 9)
                grp = {6'($urandom), v[63]};
            else
                grp = 7'($urandom);
            octet = {(i < nbytes - 1), grp};
            msg_q.insert(msg_q.size(), octet);
        end
    endtask

    function automatic logic [63:0] rand_u64();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return 64'($urandom_range(0, 127));
            2: return 64'($urandom_range(128, 65535));
            3: return {$urandom, $urandom};
            4: return '1;
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    // Field numbers lean toward the current target and its neighbors.
    function automatic logic [31:0] pick_field();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return wanted_field;
            4, 5: return 32'($urandom_range(0, 15));
            6: return wanted_field + 32'd1;
            7: return wanted_field - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Move the built message onto the send queue, flagging its final byte.
    task automatic send_message();
        msg_byte_t mb;
        for (int i = 0; i < msg_q.size(); i++)
        begin
            mb.data = msg_q[i];
            mb.last = (i == msg_q.size() - 1);
            bytes_to_send.insert(bytes_to_send.size(), mb);
        end
        bytes_queued += msg_q.size();
        msg_count++;
        msg_q.delete();
    endtask

    // Build one message of random fields; some are cut short or replaced by noise.
    task automatic build_message(input int nfields);
        logic [2:0]  wt;
        logic [28:0] hi;
        logic [63:0] tag;
        logic [63:0] len;
        int          r;
        int          cut;
        msg_q.delete();
        repeat (nfields)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                wt = pvff_pkg::WT_VARINT;
            else if (r < 55)
                wt = pvff_pkg::WT_FIX64;
            else if (r < 75)
                wt = pvff_pkg::WT_LEN;
            else if (r < 90)
                wt = pvff_pkg::WT_FIX32;
            else
                wt = 3'($urandom_range(0, 3)) + 3'(($urandom_range(0, 3) < 2) ? 3 : 4);
            hi = ($urandom_range(0, 9) == 0) ? 29'($urandom) : 29'd0;
            tag = {hi, pick_field(), wt};
            put_varint(tag, pick_len(tag));
            if (wt == pvff_pkg::WT_VARINT)
            begin
                len = rand_u64();
                put_varint(len, pick_len(len));
            end
            else if (wt == pvff_pkg::WT_FIX64 || wt == pvff_pkg::WT_FIX32)
            begin
                repeat ((wt == pvff_pkg::WT_FIX64) ? 8 : 4)
                    msg_q.insert(msg_q.size(), 8'($urandom));
            end
            else if (wt == pvff_pkg::WT_LEN)
            begin
                if ($urandom_range(0, 32) == 0)
                    len = {32'($urandom_range(1, 32'hFFFF_FFFF)), $urandom};
                else
                    len = 64'($urandom_range(0, 12));
                put_varint(len, pick_len(len));
                if (len < 64'd13)
                    repeat (int'(len))
                        msg_q.insert(msg_q.size(), 8'($urandom));
            end
        end
        r = $urandom_range(0, 99);
        if (r >= 85 && r < 95 && msg_q.size() > 1)
        begin
            cut = $urandom_range(1, msg_q.size() - 1);
            while (msg_q.size() > cut)
                void'(msg_q.pop_back());
        end
        else if (r >= 95)
        begin
            msg_q.delete();
            repeat ($urandom_range(1, 8))
                msg_q.insert(msg_q.size(), 8'($urandom));
        end
        send_message();
    endtask

    // Wait until every queued byte is taken and every expected result has come.
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0);
    endtask

    // Write the target register through its own handshake.
    task automatic write_target(input logic [31:0] t);
        @(negedge clk);
        cfg_valid <= 1'b1;
        target_field <= t;
        do
            @(posedge clk);
        while (!cfg_ready);
        wanted_field = t;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sender: bursts of items with random gaps; a stalled item is held steady.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && byte_taken)
                void'(bytes_to_send.pop_front());
            if (!(in_valid && !byte_taken))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (bytes_to_send.size() != 0)
                begin
                    data_byte <= bytes_to_send[0].data;
                    last_byte <= bytes_to_send[0].last;
                    in_valid <= 1'b1;
                    burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a changing stall pattern plus one long hold-off mid-run.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (!hold_done && bytes_in >= HOLD_AT_BYTES)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (rx_cycle % 5 < 2);
            endcase
        end
    end

    // Accepted bytes feed the decoder; accepted results are checked in order.
    always @(posedge clk)
    begin
        pvff_pkg::result_t want;
        if (rst_n)
        begin
            byte_taken = in_valid && !in_stall;
            if (byte_taken)
            begin
                decode_byte(data_byte, last_byte);
                bytes_in++;
            end
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result item: status %0d value %h", status, value);
                    error_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, value);
                        error_count++;
                    end
                    case (want.status)
                        pvff_pkg::ST_FOUND: found_count++;
                        pvff_pkg::ST_NOT_FOUND: absent_count++;
                        default: malformed_count++;
                    endcase
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus sequence: reset, directed messages, then random phases per target.
    initial
    begin
        logic [31:0] targets[8];
        int          phase_start;

        wanted_field = pvff_pkg::TARGET_RESET;
        dec = pvff_pkg::STATE_CLEAR;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed messages at the reset target: a plain match, an unknown wire type,
        // an empty length field, a length of 2^32, an over-long value and a tag that
        // ends the message.
        msg_q = '{8'h08, 8'h96, 8'h01};
        send_message();
        msg_q = '{8'h0B};
        send_message();
        msg_q = '{8'h12, 8'h00};
        send_message();
        msg_q = '{8'h12, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
        send_message();
        msg_q = '{8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'h00};
        send_message();
        msg_q = '{8'h0D};
        send_message();
        wait_drained();

        targets[0] = 32'd0;
        targets[1] = 32'hFFFF_FFFF;
        targets[2] = 32'd1;
        targets[3] = 32'($urandom_range(2, 15));
        targets[4] = $urandom;
        targets[5] = 32'd5;
        targets[6] = 32'hFFFF_FFFF;
        targets[7] = 32'd0;

        // Each phase sends its messages and then lets the block drain fully.
        foreach (targets[p])
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            write_target(targets[p]);
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES)
                build_message($urandom_range(1, 5));
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d messages across %0d target writes.",
                 bytes_in, msg_count, cfg_writes);
        $display("Checked results: %0d found, %0d not found, %0d malformed.",
                 found_count, absent_count, malformed_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
